[rtl/core/utcmt_pkg.sv]
// utcmt_pkg: shared types, constants and calendar helpers for the utc to
// mountain time converter. No dependencies; used by every file in rtl/core.
package utcmt_pkg;

   // field widths
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // quotient width of year / 100 for a 12 bit year
   localparam int CENT_W = 6;
   // sum of the weekday formula before the mod 7
   localparam int WSUM_W = 13;

   // reciprocal of 100 scaled by 2^19, exact for years below 4096
   localparam logic [12:0] RECIP100       = 13'd5243;
   localparam int          RECIP100_SHIFT = 19;

   // offsets and calendar constants
   localparam logic [2:0]          DST_BACK    = 3'd6;
   localparam logic [2:0]          STD_BACK    = 3'd7;
   localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
   localparam logic [HOUR_W-1:0]   HOURS_DAY   = 5'd24;
   localparam logic [HOUR_W-1:0]   SWITCH_HOUR = 5'd2;
   localparam logic [DAY_W-1:0]    MARCH_BASE  = 5'd14;
   localparam logic [DAY_W-1:0]    NOV_BASE    = 5'd7;
   localparam logic [WSUM_W-1:0]   WDAY_BIAS   = 13'd2;

   localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
   localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
   localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } date_type;

   // length of a month, month already limited to 1..12
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
      logic [DAY_W-1:0] n;
      case (m)
         MON_FEB:                   n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
         default:                   n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

[rtl/core/utcmt_rollback.sv]
// utcmt_rollback: steps a calendar date back by one day, clamping month and
// day into range first. Depends on utcmt_pkg.
module utcmt_rollback (
   input  utcmt_pkg::date_type date_in,
   input  logic                leap,
   output utcmt_pkg::date_type date_out
);
   import utcmt_pkg::*;

   logic [MONTH_W-1:0] month_sat;
   logic [DAY_W-1:0]   day_max;
   logic [DAY_W-1:0]   day_sat;
   logic [MONTH_W-1:0] month_prev;

   // clamp month into 1..12 and day into the month
   always_comb begin
      month_sat = date_in.month;
      if (date_in.month < MON_JAN) begin
         month_sat = MON_JAN;
      end
      if (date_in.month > MON_DEC) begin
         month_sat = MON_DEC;
      end
      day_max = days_in_month(month_sat, leap);
      day_sat = date_in.day;
      if (date_in.day == '0) begin
         day_sat = 5'd1;
      end else if (date_in.day > day_max) begin
         day_sat = day_max;
      end
   end

   assign month_prev = month_sat - 4'd1;

   // previous day, previous month end, or new year's eve of last year
   always_comb begin
      date_out = date_in;
      if (day_sat > 5'd1) begin
         date_out.month = month_sat;
         date_out.day   = day_sat - 5'd1;
      end else if (month_sat > MON_JAN) begin
         date_out.month = month_prev;
         date_out.day   = days_in_month(month_prev, leap);
      end else begin
         date_out.year  = date_in.year - 12'd1;
         date_out.month = MON_DEC;
         date_out.day   = 5'd31;
      end
   end

endmodule

[rtl/core/utc_to_mountain_time_dst.sv]
// utc_to_mountain_time_dst: four stage pipeline turning a utc time into us
// mountain local time with daylight saving. Depends on utcmt_pkg, utcmt_rollback.
//
// Usage:
//   A request carries one utc time on req_utc_* and is taken at a rising edge
//   with req_valid high and req_stall low. Each request gives exactly one
//   response on rsp_local_* and rsp_dst_active, taken at an edge with
//   rsp_valid high and rsp_stall low.
//   The request passes the stages in order; the response is the output of the last stage.
//   Throughput: one request per cycle while rsp_stall is low; four register stages (century
//   quotient, weekday sum and leap flag, weekday mod 7, offset and date
//   step) each hold one request.
//   When the receiver stalls, the response holds steady and the stages fill
//   up behind it; req_stall rises only once every stage holds a request.
//   Empty stages close up, so bubbles are not kept.
//   Synchronous reset clears all valid bits; no request is in flight after it.
module utc_to_mountain_time_dst (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [utcmt_pkg::YEAR_W-1:0]    req_utc_year,
   input  logic [utcmt_pkg::MONTH_W-1:0]   req_utc_month,
   input  logic [utcmt_pkg::DAY_W-1:0]     req_utc_day,
   input  logic [utcmt_pkg::HOUR_W-1:0]    req_utc_hour,
   input  logic [utcmt_pkg::MINUTE_W-1:0]  req_utc_minute,
   input  logic [utcmt_pkg::SECOND_W-1:0]  req_utc_second,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [utcmt_pkg::YEAR_W-1:0]    rsp_local_year,
   output logic [utcmt_pkg::MONTH_W-1:0]   rsp_local_month,
   output logic [utcmt_pkg::DAY_W-1:0]     rsp_local_day,
   output logic [utcmt_pkg::HOUR_W-1:0]    rsp_local_hour,
   output logic [utcmt_pkg::MINUTE_W-1:0]  rsp_local_minute,
   output logic [utcmt_pkg::SECOND_W-1:0]  rsp_local_second,
   output logic                            rsp_dst_active
);
   import utcmt_pkg::*;

   // per stage request fields
   typedef struct packed {
      date_type              date;
      logic [HOUR_W-1:0]     hour;
      logic [MINUTE_W-1:0]   minute;
      logic [SECOND_W-1:0]   second;
   } time_type;

   // stage valid bits and ready chain
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   // stage 1: clamp hour, year / 100 by reciprocal multiply
   time_type            t1_in, t1_ff;
   logic [24:0]         cent_prod;
   logic [CENT_W-1:0]   cent1_in, cent1_ff;

   always_comb begin
      t1_in.date.year  = req_utc_year;
      t1_in.date.month = req_utc_month;
      t1_in.date.day   = req_utc_day;
      t1_in.hour       = (req_utc_hour > HOUR_MAX) ? HOUR_MAX : req_utc_hour;
      t1_in.minute     = req_utc_minute;
      t1_in.second     = req_utc_second;
      cent_prod        = {13'd0, req_utc_year} * {12'd0, RECIP100};
      cent1_in         = cent_prod[RECIP100_SHIFT +: CENT_W];
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t1_ff    <= t1_in;
         cent1_ff <= cent1_in;
      end
   end

   // stage 2: weekday sum and leap year flag
   time_type            t2_ff;
   logic [12:0]         cent_x100;
   logic [YEAR_W-1:0]   rem100;
   logic [WSUM_W-1:0]   wsum2_in, wsum2_ff;
   logic                leap2_in, leap2_ff;

   always_comb begin
      cent_x100 = {7'd0, cent1_ff} * 13'd100;
      rem100    = t1_ff.date.year - cent_x100[YEAR_W-1:0];
      leap2_in  = (t1_ff.date.year[1:0] == 2'd0)
                  && ((rem100 != '0) || (cent1_ff[1:0] == 2'd0));
      wsum2_in  = WDAY_BIAS + {1'b0, t1_ff.date.year}
                  + {3'd0, t1_ff.date.year[YEAR_W-1:2]}
                  - {7'd0, cent1_ff} + {9'd0, cent1_ff[CENT_W-1:2]};
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         t2_ff    <= t1_ff;
         wsum2_ff <= wsum2_in;
         leap2_ff <= leap2_in;
      end
   end

   // stage 3: weekday sum mod 7 by octal digit folding
   time_type    t3_ff;
   logic [4:0]  fold_a;
   logic [3:0]  fold_b;
   logic [2:0]  wday3_in, wday3_ff;
   logic        leap3_ff;

   always_comb begin
      fold_a = {2'd0, wsum2_ff[2:0]} + {2'd0, wsum2_ff[5:3]} + {2'd0, wsum2_ff[8:6]}
               + {2'd0, wsum2_ff[11:9]} + {4'd0, wsum2_ff[12]};
      fold_b = {1'b0, fold_a[2:0]} + {2'd0, fold_a[4:3]};
      if (fold_b >= 4'd7) begin
         wday3_in = 3'(fold_b - 4'd7);
      end else begin
         wday3_in = fold_b[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         t3_ff    <= t2_ff;
         wday3_ff <= wday3_in;
         leap3_ff <= leap2_ff;
      end
   end

   // stage 4: daylight saving decision, hour offset, date step back
   logic              dst4_in;
   logic [DAY_W-1:0]  sunday;
   logic [2:0]        back;
   logic [HOUR_W-1:0] hour4_in;
   logic              wrap;
   date_type          date_back;
   date_type          date4_in;

   always_comb begin
      dst4_in = 1'b0;
      sunday  = '0;
      if (t3_ff.date.month > MON_MAR && t3_ff.date.month < MON_NOV) begin
         dst4_in = 1'b1;
      end else if (t3_ff.date.month == MON_MAR) begin
         sunday  = MARCH_BASE - {2'd0, wday3_ff};
         dst4_in = (t3_ff.date.day > sunday)
                   || ((t3_ff.date.day == sunday) && (t3_ff.hour >= SWITCH_HOUR));
      end else if (t3_ff.date.month == MON_NOV) begin
         sunday  = NOV_BASE - {2'd0, wday3_ff};
         dst4_in = (t3_ff.date.day < sunday)
                   || ((t3_ff.date.day == sunday) && (t3_ff.hour < SWITCH_HOUR));
      end
      back = dst4_in ? DST_BACK : STD_BACK;
      wrap = t3_ff.hour < {2'd0, back};
      if (wrap) begin
         hour4_in = t3_ff.hour + HOURS_DAY - {2'd0, back};
      end else begin
         hour4_in = t3_ff.hour - {2'd0, back};
      end
      date4_in = wrap ? date_back : t3_ff.date;
   end

   utcmt_rollback u_rollback (
      .date_in  (t3_ff.date),
      .leap     (leap3_ff),
      .date_out (date_back)
   );

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rsp_local_year   <= date4_in.year;
         rsp_local_month  <= date4_in.month;
         rsp_local_day    <= date4_in.day;
         rsp_local_hour   <= hour4_in;
         rsp_local_minute <= t3_ff.minute;
         rsp_local_second <= t3_ff.second;
         rsp_dst_active   <= dst4_in;
      end
   end

   assign rsp_valid = v4_ff;

endmodule
